FILE: sv/obstacle_threat_scorer_defines.svh
// Assertion macros for the obstacle threat scorer.
// Used by the top level only; define ASSERT_OFF to drop the checks.
`ifndef OBSTACLE_THREAT_SCORER_DEFINES_SVH
`define OBSTACLE_THREAT_SCORER_DEFINES_SVH
`ifndef ASSERT_OFF
`define OTS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ots check failed");
`define OTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ots check failed");
`else
`define OTS_ASSERT(lbl, cond)
`define OTS_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

FILE: sv/ots_pkg.sv
// Package for the obstacle threat scorer: item types, register codes,
// class tables and pipeline stage numbers. No dependencies.
package ots_pkg;

    typedef struct packed {
        logic [7:0]  object_class;
        logic [11:0] box_height;
        logic [23:0] area_now;
        logic [23:0] area_before;
        logic [19:0] frame_interval;
        logic [9:0]  position_weight;
    } t_in;

    typedef struct packed {
        logic [15:0] distance_m;
        logic        contact_valid;
        logic [23:0] contact_time;
        logic [31:0] danger_score;
        logic        saturated;
    } t_out;

    typedef enum logic [1:0] {
        CFG_FOCAL = 2'd0,
        CFG_DEPS  = 2'd1,
        CFG_TEPS  = 2'd2,
        CFG_GAIN  = 2'd3
    } t_cfg_idx;

    localparam logic [11:0] FOCAL_RST = 12'd800;
    localparam logic [15:0] DEPS_RST  = 16'd26;
    localparam logic [23:0] TEPS_RST  = 24'd6554;
    localparam logic [15:0] GAIN_RST  = 16'd256;

    localparam logic [19:0] MIN_INTERVAL = 20'd65;

    // stage numbers; each division runs one quotient bit per stage
    localparam int S_SAT  = 1;   // overflow pre-checks
    localparam int S_DIST = 18;  // distance done after 16 steps
    localparam int S_TTC  = 26;  // ttc done after 24 steps
    localparam int S_SUM  = 59;  // inverse and ttc term done
    localparam int S_MUL  = 60;
    localparam int S_LAST = 61;
    localparam int DEPTH  = 62;

    typedef struct packed {
        logic [19:0] wprod;
        logic        flag;
        // distance division
        logic [25:0] rem1;
        logic [15:0] den1;
        logic [15:0] q1;
        logic        sat1;
        // ttc division
        logic [43:0] rem2;
        logic [23:0] den2;
        logic [23:0] q2;
        logic        cvalid;
        logic        sat2;
        // inverse distance
        logic [15:0] dist_m;
        logic [16:0] den3;
        logic [24:0] rem3;
        logic [24:0] q3;
        logic        zero3;
        // ttc term
        logic [23:0] ttc;
        logic [24:0] den4;
        logic [39:0] rem4;
        logic [31:0] q4;
        logic        sat4;
        logic        zero4;
        // score
        logic [31:0] sum;
        logic [51:0] prod;
        logic [31:0] danger;
    } t_work;

    // real height, Q2.12 m; ids above 9 take the default entry
    function automatic logic [13:0] f_height(input logic [7:0] cls);
        logic [13:0] h;
        case (cls)
            8'd0:    h = 14'd6963;
            8'd1:    h = 14'd6144;
            8'd2:    h = 14'd614;
            8'd3:    h = 14'd12288;
            8'd4:    h = 14'd2867;
            8'd5:    h = 14'd3277;
            8'd6:    h = 14'd2458;
            8'd7:    h = 14'd2458;
            8'd8:    h = 14'd205;
            8'd9:    h = 14'd205;
            default: h = 14'd4096;
        endcase
        return h;
    endfunction

    // class weight, Q2.8
    function automatic logic [9:0] f_weight(input logic [7:0] cls);
        logic [9:0] w;
        case (cls)
            8'd0:    w = 10'd512;
            8'd1:    w = 10'd768;
            8'd2:    w = 10'd384;
            8'd3:    w = 10'd307;
            8'd4:    w = 10'd461;
            8'd5:    w = 10'd640;
            8'd6:    w = 10'd307;
            8'd7:    w = 10'd256;
            8'd8:    w = 10'd128;
            8'd9:    w = 10'd256;
            default: w = 10'd256;
        endcase
        return w;
    endfunction

endpackage

FILE: sv/obstacle_threat_scorer.sv
// The pipeline has 62 register stages; an accepted item leaves from the last one.
// Throughput: one item per cycle while the output is not stalled; the stage count is set by the bit-serial
// ttc and ttc-term divisions (24 + 32 quotient bits, one bit per stage).
// Output stall freezes the whole pipeline; input ready = !out_valid | out_ready.
// Reset (synchronous, active low) clears stage valids and loads the
// register defaults; no clearing pass.
// Top level of the obstacle threat scorer; uses ots_pkg and the defines header.
`include "obstacle_threat_scorer_defines.svh"

module obstacle_threat_scorer
    import ots_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in         i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out        o_out_item
);

    logic [11:0] r_focal;
    logic [15:0] r_deps;
    logic [23:0] r_teps;
    logic [15:0] r_gain;

    t_work       r_pipe [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic        w_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal <= FOCAL_RST;
            r_deps  <= DEPS_RST;
            r_teps  <= TEPS_RST;
            r_gain  <= GAIN_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FOCAL: r_focal <= i_cfg_data[11:0];
                CFG_DEPS:  r_deps  <= i_cfg_data[15:0];
                CFG_TEPS:  r_teps  <= i_cfg_data;
                CFG_GAIN:  r_gain  <= i_cfg_data[15:0];
            endcase
        end
    end

    function automatic t_work f_init(input t_in d);
        t_work w;
        w = '0;
        w.wprod  = 20'(f_weight(d.object_class)) * 20'(d.position_weight);
        w.rem1   = 26'(r_focal) * 26'(f_height(d.object_class));
        w.den1   = {d.box_height, 4'b0};
        w.rem2   = 44'(d.area_now) * 44'(d.frame_interval);
        w.den2   = d.area_now - d.area_before;
        w.cvalid = (d.area_before != '0) && (d.frame_interval > MIN_INTERVAL)
                   && (25'(d.area_now) >= 25'(d.area_before) + 25'd2);
        return w;
    endfunction

    function automatic t_work f_step(input int k, input t_work wi);
        t_work       w;
        int          j;
        logic [41:0] sh1;
        logic [47:0] sh2;
        logic [41:0] sh3;
        logic [56:0] sh4;
        logic [32:0] s33;
        logic [35:0] p;
        w = wi;
        if (k == S_SAT) begin
            w.sat1 = (wi.den1 == '0) || (42'(wi.rem1) >= (42'(wi.den1) << 16));
            w.sat2 = wi.cvalid && (68'(wi.rem2) >= (68'(wi.den2) << 24));
            w.flag = wi.flag | w.sat1 | w.sat2;
        end
        if (k > S_SAT && k <= S_SAT + 16) begin
            j   = S_SAT + 16 - k;
            sh1 = 42'(wi.den1) << j;
            if (42'(wi.rem1) >= sh1) begin
                w.rem1 = wi.rem1 - sh1[25:0];
                w.q1[j] = 1'b1;
            end
        end
        if (k > S_SAT && k <= S_SAT + 24) begin
            j   = S_SAT + 24 - k;
            sh2 = 48'(wi.den2) << j;
            if (48'(wi.rem2) >= sh2) begin
                w.rem2 = wi.rem2 - sh2[43:0];
                w.q2[j] = 1'b1;
            end
        end
        if (k == S_DIST) begin
            w.dist_m = wi.sat1 ? 16'hFFFF : wi.q1;
            w.den3   = 17'(w.dist_m) + 17'(r_deps);
            w.zero3  = (w.den3 == '0);
            w.flag   = wi.flag | w.zero3;
            w.rem3   = 25'h1000000;
        end
        if (k > S_DIST && k <= S_DIST + 25) begin
            j   = S_DIST + 25 - k;
            sh3 = 42'(wi.den3) << j;
            if (42'(wi.rem3) >= sh3) begin
                w.rem3 = wi.rem3 - sh3[24:0];
                w.q3[j] = 1'b1;
            end
        end
        if (k == S_TTC) begin
            w.ttc   = !wi.cvalid ? 24'd0 : (wi.sat2 ? 24'hFFFFFF : wi.q2);
            w.den4  = 25'(w.ttc) + 25'(r_teps);
            w.rem4  = {r_gain, 24'b0};
            w.zero4 = (w.den4 == '0);
            w.sat4  = 57'(w.rem4) >= (57'(w.den4) << 32);
        end
        if (k > S_TTC && k <= S_TTC + 32) begin
            j   = S_TTC + 32 - k;
            sh4 = 57'(wi.den4) << j;
            if (57'(wi.rem4) >= sh4) begin
                w.rem4 = wi.rem4 - sh4[39:0];
                w.q4[j] = 1'b1;
            end
        end
        if (k == S_SUM) begin
            s33 = 33'(wi.zero3 ? 32'hFFFF_FFFF : 32'(wi.q3));
            if (wi.cvalid) begin
                s33 = s33 + 33'((wi.zero4 || wi.sat4) ? 32'hFFFF_FFFF : wi.q4);
            end
            w.flag = wi.flag | (wi.cvalid & (wi.zero4 | wi.sat4)) | s33[32];
            w.sum  = s33[32] ? 32'hFFFF_FFFF : s33[31:0];
        end
        if (k == S_MUL) begin
            w.prod = 52'(wi.wprod) * 52'(wi.sum);
        end
        if (k == S_LAST) begin
            p        = wi.prod[51:16];
            w.danger = (p[35:32] != '0) ? 32'hFFFF_FFFF : p[31:0];
            w.flag   = wi.flag | (p[35:32] != '0);
        end
        return w;
    endfunction

    assign w_en       = !r_vld[S_LAST] || i_out_ready;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[DEPTH-2:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pipe[0] <= f_init(i_in_item);
        end
    end

    for (genvar g = 1; g < DEPTH; g++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pipe[g] <= f_step(g, r_pipe[g-1]);
            end
        end
    end

    assign o_out_valid               = r_vld[S_LAST];
    assign o_out_item.distance_m     = r_pipe[S_LAST].dist_m;
    assign o_out_item.contact_valid  = r_pipe[S_LAST].cvalid;
    assign o_out_item.contact_time   = r_pipe[S_LAST].ttc;
    assign o_out_item.danger_score   = r_pipe[S_LAST].danger;
    assign o_out_item.saturated      = r_pipe[S_LAST].flag;

    `OTS_ASSERT_IMP(a_ttc_zero, o_out_valid && !o_out_item.contact_valid, o_out_item.contact_time == '0)
    `OTS_ASSERT_IMP(a_inv_range, r_vld[S_SUM] && !r_pipe[S_SUM].zero3, r_pipe[S_SUM].q3 <= 25'h1000000)
    `OTS_ASSERT_IMP(a_stall_hold, r_vld[S_LAST] && !i_out_ready, !o_in_ready)

endmodule
